/* src/curj_pkg.sv */
// shared types and constants for the canvas undo/redo journal
// no dependencies; imported by every module of the block but curj_ram

package curj_pkg;

	localparam int GRID_DIM      = 16;
	localparam int HISTORY_DEPTH = 16;

	localparam int IN_COORD_W = 5;
	localparam int COORD_W    = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
	localparam int CELLS      = GRID_DIM * GRID_DIM;
	localparam int CELL_AW    = $clog2(CELLS);
	localparam int HIST_AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int HIST_CW    = $clog2(HISTORY_DEPTH + 1);
	localparam int HIST_SW    = HIST_CW + 1;

	localparam logic [7:0] BLANK_CHAR = 8'h2E;

	typedef enum logic [2:0] {
		OP_DRAW  = 3'd0,
		OP_MOVE  = 3'd1,
		OP_ERASE = 3'd2,
		OP_UNDO  = 3'd3,
		OP_REDO  = 3'd4,
		OP_READ  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		STS_DONE      = 3'd0,
		STS_BAD_COORD = 3'd1,
		STS_BLANK     = 3'd2,
		STS_NO_UNDO   = 3'd3,
		STS_NO_REDO   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KIND_DRAW  = 2'd0,
		KIND_MOVE  = 2'd1,
		KIND_ERASE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC1,
		S_EXEC2,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]            op;
		logic [IN_COORD_W-1:0] x_first;
		logic [IN_COORD_W-1:0] y_first;
		logic [IN_COORD_W-1:0] x_second;
		logic [IN_COORD_W-1:0] y_second;
		logic [7:0]            char_in;
	} req_beat_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] cell_char;
		logic [1:0] replayed_kind;
	} rsp_beat_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [COORD_W-1:0] xs;
		logic [COORD_W-1:0] ys;
		logic [COORD_W-1:0] xd;
		logic [COORD_W-1:0] yd;
		logic [7:0]         prev_ch;
		logic [7:0]         new_ch;
	} hist_entry_t;

	localparam int ENTRY_W = $bits(hist_entry_t);

	typedef struct packed {
		logic accept;
		logic exec1;
		logic exec2;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic two_step;
		logic out_free;
	} ctrl_stat_t;

endpackage

/* src/canvas_undo_redo_journal_unit.sv */
// top level of the canvas undo/redo journal: controller plus datapath
// depends on curj_pkg, curj_ctrl, curj_dpath (and curj_ram below it)
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------------
//   req     | req_valid / req_stall  | op, x/y first, x/y second, char_in
//   rsp     | rsp_valid / rsp_stall  | status, cell_char, replayed_kind
//
// one beat in flight: accept, a first execute step, a second execute step for a
// move or a replayed move (second grid write on the single-port grid ram),
// then the result goes to the output register in the cycle the next beat may
// enter. reset leaves the grid blank through per-cell valid bits, so no
// clearing pass. a stalled output holds the block in its final step until the
// output register frees up.

module canvas_undo_redo_journal_unit import curj_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	curj_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	curj_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

/* src/curj_ram.sv */
// generic single-port ram with registered read data
// no dependencies

module curj_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/curj_ctrl.sv */
// sequencer for the journal: accept, one or two execute steps, result hand-off
// depends on curj_pkg

module curj_ctrl import curj_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   take_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		take_ok      = (state_q == S_IDLE) || ((state_q == S_FIN) && stat.out_free);
		req_stall    = !take_ok;
		cmd.accept   = req_valid && take_ok;
		cmd.exec1    = (state_q == S_EXEC1);
		cmd.exec2    = (state_q == S_EXEC2);
		cmd.load_out = (state_q == S_FIN) && stat.out_free;
		state_d      = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.accept) state_d = S_EXEC1;
			end
			S_EXEC1: begin
				state_d = stat.two_step ? S_EXEC2 : S_FIN;
			end
			S_EXEC2: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				// next beat may enter while this result leaves
				if (stat.out_free) state_d = cmd.accept ? S_EXEC1 : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* src/curj_dpath.sv */
// datapath: grid ram with per-cell valid bits, two ring-buffer history stacks,
// result and output registers; depends on curj_pkg and curj_ram

module curj_dpath import curj_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  req_beat_t  req,
	output rsp_beat_t  rsp,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	input  ctrl_cmd_t  cmd,
	output ctrl_stat_t stat
);

	function automatic logic [CELL_AW-1:0] cell_addr(input logic [COORD_W-1:0] x,
	                                                 input logic [COORD_W-1:0] y);
		cell_addr = CELL_AW'(y) * CELL_AW'(GRID_DIM) + CELL_AW'(x);
	endfunction

	function automatic logic coord_ok(input logic [IN_COORD_W-1:0] x,
	                                  input logic [IN_COORD_W-1:0] y);
		coord_ok = ((IN_COORD_W+1)'(x) < (IN_COORD_W+1)'(GRID_DIM)) &&
		           ((IN_COORD_W+1)'(y) < (IN_COORD_W+1)'(GRID_DIM));
	endfunction

	// sum stays below twice the depth while the stack is not empty, so one subtract folds it back
	function automatic logic [HIST_AW-1:0] wrap_idx(input logic [HIST_SW-1:0] s);
		if (s >= HIST_SW'(HISTORY_DEPTH)) begin
			wrap_idx = HIST_AW'(s - HIST_SW'(HISTORY_DEPTH));
		end else begin
			wrap_idx = HIST_AW'(s);
		end
	endfunction

	req_beat_t in_q;
	rsp_beat_t res_q, res_d, out_q;
	logic      out_valid_q;

	logic [CELLS-1:0]   gvld_q;
	logic               gvld_s1;
	logic [CELL_AW-1:0] rd_addr, g_addr, g_waddr1, sec_addr_q, sec_addr_d;
	logic [7:0]         g_wdata, g_wdata1, g_rdata, sec_data_q, sec_data_d, gch;
	logic               g_we, g_we1, sec_we;

	logic [HIST_AW-1:0] u_base_q, r_base_q, u_top, r_top, u_pidx, r_pidx, u_addr, r_addr;
	logic [HIST_CW-1:0] u_cnt_q, r_cnt_q;
	logic               u_full, r_full, u_push, u_pop, r_push, r_pop, r_clear;
	logic [ENTRY_W-1:0] u_rdata, r_rdata;
	hist_entry_t        ue, re, u_entry;

	logic               ok_a, ok_b;
	logic [CELL_AW-1:0] addr_a, addr_b;

	// ---------------- grid ----------------
	assign rd_addr = cell_addr(req.x_first[COORD_W-1:0], req.y_first[COORD_W-1:0]);
	assign g_we    = (cmd.exec1 && g_we1) || cmd.exec2;
	assign g_addr  = cmd.exec2 ? sec_addr_q : (cmd.exec1 ? g_waddr1 : rd_addr);
	assign g_wdata = cmd.exec2 ? sec_data_q : g_wdata1;
	assign gch     = gvld_s1 ? g_rdata : BLANK_CHAR;

	curj_ram #(.WIDTH(8), .DEPTH(CELLS)) u_grid (
		.clk   (clk),
		.we    (g_we),
		.addr  (g_addr),
		.wdata (g_wdata),
		.rdata (g_rdata)
	);

	// a cell never written reads as blank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gvld_q <= '0;
		end else if (g_we) begin
			gvld_q[g_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			gvld_s1 <= gvld_q[rd_addr];
			in_q    <= req;
		end
	end

	// ---------------- history stacks ----------------
	assign u_full = (u_cnt_q == HIST_CW'(HISTORY_DEPTH));
	assign r_full = (r_cnt_q == HIST_CW'(HISTORY_DEPTH));
	assign u_top  = wrap_idx(HIST_SW'(u_base_q) + HIST_SW'(u_cnt_q) - HIST_SW'(1));
	assign r_top  = wrap_idx(HIST_SW'(r_base_q) + HIST_SW'(r_cnt_q) - HIST_SW'(1));
	assign u_pidx = u_full ? u_base_q : wrap_idx(HIST_SW'(u_base_q) + HIST_SW'(u_cnt_q));
	assign r_pidx = r_full ? r_base_q : wrap_idx(HIST_SW'(r_base_q) + HIST_SW'(r_cnt_q));
	assign u_addr = (cmd.exec1 && u_push) ? u_pidx : u_top;
	assign r_addr = (cmd.exec1 && r_push) ? r_pidx : r_top;
	assign ue     = hist_entry_t'(u_rdata);
	assign re     = hist_entry_t'(r_rdata);

	curj_ram #(.WIDTH(ENTRY_W), .DEPTH(HISTORY_DEPTH)) u_undo (
		.clk   (clk),
		.we    (cmd.exec1 && u_push),
		.addr  (u_addr),
		.wdata (u_entry),
		.rdata (u_rdata)
	);

	// redo only ever receives the entry just popped from undo
	curj_ram #(.WIDTH(ENTRY_W), .DEPTH(HISTORY_DEPTH)) u_redo (
		.clk   (clk),
		.we    (cmd.exec1 && r_push),
		.addr  (r_addr),
		.wdata (ue),
		.rdata (r_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_base_q <= '0;
			u_cnt_q  <= '0;
			r_base_q <= '0;
			r_cnt_q  <= '0;
		end else if (cmd.exec1) begin
			if (u_pop) begin
				u_cnt_q <= u_cnt_q - HIST_CW'(1);
			end else if (u_push) begin
				if (u_full) u_base_q <= wrap_idx(HIST_SW'(u_base_q) + HIST_SW'(1));
				else        u_cnt_q  <= u_cnt_q + HIST_CW'(1);
			end
			if (r_clear) begin
				r_cnt_q <= '0;
			end else if (r_pop) begin
				r_cnt_q <= r_cnt_q - HIST_CW'(1);
			end else if (r_push) begin
				if (r_full) r_base_q <= wrap_idx(HIST_SW'(r_base_q) + HIST_SW'(1));
				else        r_cnt_q  <= r_cnt_q + HIST_CW'(1);
			end
		end
	end

	// ---------------- first execute step ----------------
	assign ok_a   = coord_ok(in_q.x_first, in_q.y_first);
	assign ok_b   = coord_ok(in_q.x_second, in_q.y_second);
	assign addr_a = cell_addr(in_q.x_first[COORD_W-1:0], in_q.y_first[COORD_W-1:0]);
	assign addr_b = cell_addr(in_q.x_second[COORD_W-1:0], in_q.y_second[COORD_W-1:0]);

	always_comb begin
		g_we1      = 1'b0;
		g_waddr1   = addr_a;
		g_wdata1   = BLANK_CHAR;
		sec_we     = 1'b0;
		sec_addr_d = addr_a;
		sec_data_d = BLANK_CHAR;
		u_push     = 1'b0;
		u_pop      = 1'b0;
		r_push     = 1'b0;
		r_pop      = 1'b0;
		r_clear    = 1'b0;
		u_entry    = '0;
		res_d      = '0;
		res_d.status = STS_DONE;
		case (in_q.op)
			OP_DRAW: begin
				if (!ok_a) begin
					res_d.status = STS_BAD_COORD;
				end else begin
					g_we1           = 1'b1;
					g_wdata1        = in_q.char_in;
					u_push          = 1'b1;
					r_clear         = 1'b1;
					u_entry.kind    = KIND_DRAW;
					u_entry.xs      = in_q.x_first[COORD_W-1:0];
					u_entry.ys      = in_q.y_first[COORD_W-1:0];
					u_entry.prev_ch = gch;
					u_entry.new_ch  = in_q.char_in;
				end
			end
			OP_MOVE: begin
				if (!ok_a || !ok_b) begin
					res_d.status = STS_BAD_COORD;
				end else if (gch == BLANK_CHAR) begin
					res_d.status = STS_BLANK;
				end else begin
					// destination first, then blank the source
					g_we1           = 1'b1;
					g_waddr1        = addr_b;
					g_wdata1        = gch;
					sec_we          = 1'b1;
					sec_addr_d      = addr_a;
					u_push          = 1'b1;
					r_clear         = 1'b1;
					u_entry.kind    = KIND_MOVE;
					u_entry.xs      = in_q.x_first[COORD_W-1:0];
					u_entry.ys      = in_q.y_first[COORD_W-1:0];
					u_entry.xd      = in_q.x_second[COORD_W-1:0];
					u_entry.yd      = in_q.y_second[COORD_W-1:0];
					u_entry.prev_ch = gch;
					u_entry.new_ch  = BLANK_CHAR;
				end
			end
			OP_ERASE: begin
				if (!ok_a) begin
					res_d.status = STS_BAD_COORD;
				end else if (gch == BLANK_CHAR) begin
					res_d.status = STS_BLANK;
				end else begin
					g_we1           = 1'b1;
					u_push          = 1'b1;
					r_clear         = 1'b1;
					u_entry.kind    = KIND_ERASE;
					u_entry.xs      = in_q.x_first[COORD_W-1:0];
					u_entry.ys      = in_q.y_first[COORD_W-1:0];
					u_entry.prev_ch = gch;
					u_entry.new_ch  = BLANK_CHAR;
				end
			end
			OP_UNDO: begin
				if (u_cnt_q == '0) begin
					res_d.status = STS_NO_UNDO;
				end else begin
					u_pop               = 1'b1;
					r_push              = 1'b1;
					g_we1               = 1'b1;
					g_waddr1            = cell_addr(ue.xs, ue.ys);
					g_wdata1            = ue.prev_ch;
					sec_we              = (ue.kind == KIND_MOVE);
					sec_addr_d          = cell_addr(ue.xd, ue.yd);
					res_d.replayed_kind = ue.kind;
				end
			end
			OP_REDO: begin
				if (r_cnt_q == '0) begin
					res_d.status = STS_NO_REDO;
				end else begin
					r_pop               = 1'b1;
					u_push              = 1'b1;
					u_entry             = re;
					g_we1               = 1'b1;
					res_d.replayed_kind = re.kind;
					if (re.kind == KIND_MOVE) begin
						g_waddr1   = cell_addr(re.xd, re.yd);
						g_wdata1   = re.prev_ch;
						sec_we     = 1'b1;
						sec_addr_d = cell_addr(re.xs, re.ys);
					end else begin
						g_waddr1 = cell_addr(re.xs, re.ys);
						g_wdata1 = re.new_ch;
					end
				end
			end
			OP_READ: begin
				if (!ok_a) res_d.status = STS_BAD_COORD;
				else       res_d.cell_char = gch;
			end
			default: res_d.status = STS_BAD_COORD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec1) begin
			res_q      <= res_d;
			sec_addr_q <= sec_addr_d;
			sec_data_q <= sec_data_d;
		end
		if (cmd.load_out) out_q <= res_q;
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp           = out_q;
	assign rsp_valid     = out_valid_q;
	assign stat.out_free = !out_valid_q || !rsp_stall;
	assign stat.two_step = sec_we;

endmodule
